/* sv/gne_pkg.sv */
package gne_pkg;

	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_MAX_ROWS = 64;
	localparam int CELL_LIMIT   = 64;

	localparam int COORD_W   = 6;   // cell coordinate
	localparam int EXT_W     = 7;   // grid extent register, also signed-wrap coordinate
	localparam int STEP_W    = 4;   // step 0 is the query cell, 1..8 the neighbors
	localparam int CFG_IDX_W = 1;

	localparam logic [STEP_W-1:0] FIRST_STEP = '0;
	localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(8);

	localparam logic [EXT_W-1:0] OFS_NEG  = {EXT_W{1'b1}};
	localparam logic [EXT_W-1:0] OFS_ZERO = '0;
	localparam logic [EXT_W-1:0] OFS_POS  = EXT_W'(1);

	localparam logic [EXT_W-1:0] EXT_RESET = EXT_W'(64);

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_NONE = 2'd1,
		STATUS_BAD  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_Q_RUN,
		ST_Q_EVAL,
		ST_Q_TAIL
	} state_t;

	// one in-flight occupancy lookup, lined up with the RAM read data
	typedef struct packed {
		logic               valid;
		logic               first;
		logic               last_step;
		logic               inb;
		logic               diag;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} probe_t;

	// neighbor order: (-1,-1) (-1,0) (0,-1) (+1,+1) (+1,0) (0,+1) (+1,-1) (-1,+1)
	function automatic logic [EXT_W-1:0] step_dx(input logic [STEP_W-1:0] step);
		logic [EXT_W-1:0] d;
		unique case (step)
			4'd1, 4'd2, 4'd8: d = OFS_NEG;
			4'd4, 4'd5, 4'd7: d = OFS_POS;
			default:          d = OFS_ZERO;
		endcase
		return d;
	endfunction

	function automatic logic [EXT_W-1:0] step_dy(input logic [STEP_W-1:0] step);
		logic [EXT_W-1:0] d;
		unique case (step)
			4'd1, 4'd3, 4'd7: d = OFS_NEG;
			4'd4, 4'd6, 4'd8: d = OFS_POS;
			default:          d = OFS_ZERO;
		endcase
		return d;
	endfunction

	function automatic logic step_diag(input logic [STEP_W-1:0] step);
		logic d;
		unique case (step)
			4'd1, 4'd4, 4'd7, 4'd8: d = 1'b1;
			default:                d = 1'b0;
		endcase
		return d;
	endfunction

endpackage

/* sv/gne_ram.sv */
module gne_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/gne_ctrl.sv */
module gne_ctrl #(
	parameter int MAX_COLS = gne_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = gne_pkg::DEF_MAX_ROWS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            opcode,
	input  logic [gne_pkg::COORD_W-1:0]     cell_x,
	input  logic [gne_pkg::COORD_W-1:0]     cell_y,
	input  logic                            occupied_in,
	input  logic                            cfg_valid,
	input  logic [gne_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gne_pkg::EXT_W-1:0]       cfg_data,
	input  logic                            abort,
	output logic                            busy,
	output logic                            mem_we,
	output logic [$clog2(MAX_ROWS)-1:0]     mem_waddr,
	output logic [MAX_COLS-1:0]             mem_wdata,
	output logic                            mem_re,
	output logic [$clog2(MAX_ROWS)-1:0]     mem_raddr,
	input  logic [MAX_COLS-1:0]             mem_rdata,
	output gne_pkg::probe_t                 probe_s1
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int LIM_X = (MAX_COLS < gne_pkg::CELL_LIMIT) ? MAX_COLS : gne_pkg::CELL_LIMIT;
	localparam int LIM_Y = (MAX_ROWS < gne_pkg::CELL_LIMIT) ? MAX_ROWS : gne_pkg::CELL_LIMIT;
	localparam logic [gne_pkg::EXT_W-1:0] LIM_X_V = gne_pkg::EXT_W'(LIM_X);
	localparam logic [gne_pkg::EXT_W-1:0] LIM_Y_V = gne_pkg::EXT_W'(LIM_Y);
	localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

	gne_pkg::state_t state_q, state_nx;

	logic [RW-1:0]                  clr_row_q;
	logic [gne_pkg::STEP_W-1:0]     step_q;
	logic [gne_pkg::COORD_W-1:0]    cx_q, cy_q;
	logic                           occ_q;
	logic [gne_pkg::EXT_W-1:0]      grid_width_q, grid_height_q;

	logic [gne_pkg::EXT_W-1:0]      ext_x, ext_y, cur_x, cur_y;
	logic                           cur_inb;
	logic                           accept;

	assign accept = start && (state_q == gne_pkg::ST_IDLE);

	// extent in use: register clipped to the supported grid
	assign ext_x = (grid_width_q  > LIM_X_V) ? LIM_X_V : grid_width_q;
	assign ext_y = (grid_height_q > LIM_Y_V) ? LIM_Y_V : grid_height_q;

	// -1 wraps to 127, +1 from 63 gives 64: both fail the bound check
	assign cur_x   = {1'b0, cx_q} + gne_pkg::step_dx(step_q);
	assign cur_y   = {1'b0, cy_q} + gne_pkg::step_dy(step_q);
	assign cur_inb = (cur_x < ext_x) && (cur_y < ext_y);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			gne_pkg::ST_CLEAR: begin
				if (clr_row_q == LAST_ROW) state_nx = gne_pkg::ST_IDLE;
			end
			gne_pkg::ST_IDLE: begin
				if (start) begin
					state_nx = (opcode == gne_pkg::OP_WRITE) ? gne_pkg::ST_WR_RD
					                                         : gne_pkg::ST_Q_RUN;
				end
			end
			gne_pkg::ST_WR_RD:  state_nx = gne_pkg::ST_WR_WB;
			gne_pkg::ST_WR_WB:  state_nx = gne_pkg::ST_IDLE;
			gne_pkg::ST_Q_RUN: begin
				if (abort) state_nx = gne_pkg::ST_IDLE;
				else if (step_q == gne_pkg::LAST_STEP) state_nx = gne_pkg::ST_Q_EVAL;
			end
			gne_pkg::ST_Q_EVAL: state_nx = gne_pkg::ST_Q_TAIL;
			gne_pkg::ST_Q_TAIL: state_nx = gne_pkg::ST_IDLE;
			default:            state_nx = gne_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != gne_pkg::ST_IDLE);
		mem_re    = (state_q == gne_pkg::ST_WR_RD) || (state_q == gne_pkg::ST_Q_RUN);
		mem_raddr = RW'(cur_y);
		mem_we    = 1'b0;
		mem_waddr = RW'(cur_y);
		mem_wdata = mem_rdata;
		mem_wdata[CW'(cx_q)] = occ_q;
		unique case (state_q)
			gne_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_row_q;
				mem_wdata = '0;
			end
			gne_pkg::ST_WR_WB: mem_we = cur_inb;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= gne_pkg::ST_CLEAR;
			clr_row_q      <= '0;
			step_q         <= gne_pkg::FIRST_STEP;
			grid_width_q   <= gne_pkg::EXT_RESET;
			grid_height_q  <= gne_pkg::EXT_RESET;
			probe_s1       <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == gne_pkg::ST_CLEAR) clr_row_q <= clr_row_q + RW'(1);
			if (accept) begin
				step_q <= gne_pkg::FIRST_STEP;
			end else if (state_q == gne_pkg::ST_Q_RUN && step_q != gne_pkg::LAST_STEP) begin
				step_q <= step_q + gne_pkg::STEP_W'(1);
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					gne_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
					gne_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				endcase
			end
			probe_s1.valid     <= (state_q == gne_pkg::ST_Q_RUN) && !abort;
			probe_s1.first     <= (step_q == gne_pkg::FIRST_STEP);
			probe_s1.last_step <= (step_q == gne_pkg::LAST_STEP);
			probe_s1.inb       <= cur_inb;
			probe_s1.diag      <= gne_pkg::step_diag(step_q);
			probe_s1.x         <= cur_x[gne_pkg::COORD_W-1:0];
			probe_s1.y         <= cur_y[gne_pkg::COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q  <= cell_x;
			cy_q  <= cell_y;
			occ_q <= occupied_in;
		end
	end

endmodule

/* sv/gne_eval.sv */
module gne_eval #(
	parameter int MAX_COLS = gne_pkg::DEF_MAX_COLS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gne_pkg::probe_t              probe_s1,
	input  logic [MAX_COLS-1:0]          mem_rdata,
	output logic                         abort,
	output logic                         result_strobe,
	output logic [gne_pkg::COORD_W-1:0]  neighbor_x,
	output logic [gne_pkg::COORD_W-1:0]  neighbor_y,
	output logic                         is_diagonal,
	output logic [1:0]                   status,
	output logic                         last
);

	localparam int CW = $clog2(MAX_COLS);

	logic                        occ, free;
	logic                        hold_v_q, tail_q;
	logic [gne_pkg::COORD_W-1:0] hold_x_q, hold_y_q;
	logic                        hold_d_q;

	logic                        emit;
	logic [gne_pkg::COORD_W-1:0] e_x, e_y;
	logic                        e_d, e_last;
	gne_pkg::status_t            e_status;

	logic                        strobe_q;
	logic [gne_pkg::COORD_W-1:0] x_q, y_q;
	logic                        d_q, last_q;
	gne_pkg::status_t            status_q;

	assign occ  = mem_rdata[CW'(probe_s1.x)];
	assign free = probe_s1.inb && !occ;

	// a free neighbor waits in the hold register until the next one shows
	// up or the scan ends, so that last can be set on it
	always_comb begin
		emit     = 1'b0;
		abort    = 1'b0;
		e_x      = '0;
		e_y      = '0;
		e_d      = 1'b0;
		e_last   = 1'b0;
		e_status = gne_pkg::STATUS_OK;
		if (probe_s1.valid && probe_s1.first) begin
			if (!free) begin
				emit     = 1'b1;
				abort    = 1'b1;
				e_last   = 1'b1;
				e_status = gne_pkg::STATUS_BAD;
			end
		end else if (probe_s1.valid && free && hold_v_q) begin
			emit = 1'b1;
			e_x  = hold_x_q;
			e_y  = hold_y_q;
			e_d  = hold_d_q;
		end else if (tail_q) begin
			emit   = 1'b1;
			e_last = 1'b1;
			if (hold_v_q) begin
				e_x = hold_x_q;
				e_y = hold_y_q;
				e_d = hold_d_q;
			end else begin
				e_status = gne_pkg::STATUS_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			tail_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			tail_q   <= probe_s1.valid && probe_s1.last_step;
			strobe_q <= emit;
			if (probe_s1.valid && !probe_s1.first && free) hold_v_q <= 1'b1;
			else if (tail_q) hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (probe_s1.valid && !probe_s1.first && free) begin
			hold_x_q <= probe_s1.x;
			hold_y_q <= probe_s1.y;
			hold_d_q <= probe_s1.diag;
		end
		x_q      <= e_x;
		y_q      <= e_y;
		d_q      <= e_d;
		last_q   <= e_last;
		status_q <= e_status;
	end

	assign result_strobe = strobe_q;
	assign neighbor_x    = x_q;
	assign neighbor_y    = y_q;
	assign is_diagonal   = d_q;
	assign status        = status_q;
	assign last          = last_q;

endmodule

/* sv/grid_neighbor_expander.sv */
// Write item: busy through a row read and a row write-back after the accepting edge.
// Query item: the occupancy RAM port takes one read per cycle for the query cell and
// its 8 neighbors, then the sequencer passes an evaluate and a flush state. A bad cell
// ends the query early. Results cannot be stalled. Reset: grid extents return to 64x64,
// then a clearing pass over all MAX_ROWS rows zeroes the occupancy map, with busy high
// throughout.
module grid_neighbor_expander #(
	parameter int MAX_COLS = gne_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = gne_pkg::DEF_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command side
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [gne_pkg::COORD_W-1:0]   cell_x,
	input  logic [gne_pkg::COORD_W-1:0]   cell_y,
	input  logic                          occupied_in,
	// result side, one transfer per strobe cycle
	output logic                          result_strobe,
	output logic [gne_pkg::COORD_W-1:0]   neighbor_x,
	output logic [gne_pkg::COORD_W-1:0]   neighbor_y,
	output logic                          is_diagonal,
	output logic [1:0]                    status,
	output logic                          last,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [gne_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gne_pkg::EXT_W-1:0]     cfg_data
);

	localparam int RW = $clog2(MAX_ROWS);

	// Occupancy map is stored one grid row per RAM word, so a lookup is a row
	// read followed by a column select on the registered read data.
	logic                mem_we, mem_re;
	logic [RW-1:0]       mem_waddr, mem_raddr;
	logic [MAX_COLS-1:0] mem_wdata, mem_rdata;

	gne_pkg::probe_t     probe_s1;
	logic                abort;

	// registers are to be written only while idle; the block does not enforce this, and writes are always taken
	assign cfg_ready = 1'b1;

	gne_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer: clearing pass, read-modify-write for writes, and the
	// nine-read scan for queries. A scan read is issued every cycle; the
	// matching probe descriptor travels alongside as probe_s1.
	gne_ctrl #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.opcode      (opcode),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.occupied_in (occupied_in),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.abort       (abort),
		.busy        (busy),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.probe_s1    (probe_s1)
	);

	// Evaluation: checks each returned bit, holds one free neighbor back so
	// the final one can carry last, and registers the result ports. A blocked
	// or off-grid query cell raises abort, which stops the scan early.
	gne_eval #(
		.MAX_COLS (MAX_COLS)
	) u_eval (
		.clk           (clk),
		.arst_n        (arst_n),
		.probe_s1      (probe_s1),
		.mem_rdata     (mem_rdata),
		.abort         (abort),
		.result_strobe (result_strobe),
		.neighbor_x    (neighbor_x),
		.neighbor_y    (neighbor_y),
		.is_diagonal   (is_diagonal),
		.status        (status),
		.last          (last)
	);

endmodule

/* sv/gne_checker.sv */
module gne_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        result_strobe,
	input logic [gne_pkg::COORD_W-1:0] neighbor_x,
	input logic [gne_pkg::COORD_W-1:0] neighbor_y,
	input logic                        is_diagonal,
	input logic [1:0]                  status,
	input logic                        last
);

	// busy is high in the cycle after a command is accepted
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after a command transfer");

	// error and empty results close the query
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && status != gne_pkg::STATUS_OK) |-> last)
		else $error("non-neighbor status without last");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && status != gne_pkg::STATUS_OK)
		|-> (neighbor_x == '0 && neighbor_y == '0 && !is_diagonal))
		else $error("non-neighbor status with nonzero fields");

	// a new query cannot produce a result right after the previous one ended
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |=> !result_strobe)
		else $error("result right after last");

endmodule

bind grid_neighbor_expander gne_checker u_gne_checker (.*);

/* tb/grid_neighbor_expander_checker.sv */
module grid_neighbor_expander_checker
	import gne_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               opcode,
	input  logic [COORD_W-1:0] cell_x,
	input  logic [COORD_W-1:0] cell_y,
	input  logic               occupied_in,
	input  logic               result_strobe,
	input  logic [COORD_W-1:0] neighbor_x,
	input  logic [COORD_W-1:0] neighbor_y,
	input  logic               is_diagonal,
	input  logic [1:0]         status,
	input  logic               last,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [EXT_W-1:0]   cfg_data,
	output int                 fail_count,
	output int                 pending
);

	localparam int COLS = DEF_MAX_COLS;
	localparam int ROWS = DEF_MAX_ROWS;

	typedef struct packed {
		logic [COORD_W-1:0] nx;
		logic [COORD_W-1:0] ny;
		logic               diag;
		status_t            st;
		logic               fin;
	} hop_t;

	// visit order of the eight neighbors
	int nbr_dx [0:7] = '{-1, -1, 0, 1, 1, 0, 1, -1};
	int nbr_dy [0:7] = '{-1, 0, -1, 1, 0, 1, -1, 1};

	bit               blocked [0:COLS*ROWS-1];
	logic [EXT_W-1:0] width_reg;
	logic [EXT_W-1:0] height_reg;
	hop_t             due_hops [$];
	int               errs;

	function automatic int span(input logic [EXT_W-1:0] r, input int dim_max);
		int lim;
		lim = (dim_max < CELL_LIMIT) ? dim_max : CELL_LIMIT;
		return (int'(r) > lim) ? lim : int'(r);
	endfunction

	// expected results of one query, appended in order
	task automatic expand_query(input logic [COORD_W-1:0] qx, input logic [COORD_W-1:0] qy);
		int   cols;
		int   rows;
		int   nx;
		int   ny;
		int   found;
		hop_t h;
		hop_t hops [0:7];
		cols  = span(width_reg, COLS);
		rows  = span(height_reg, ROWS);
		found = 0;
		h.nx   = '0;
		h.ny   = '0;
		h.diag = 1'b0;
		h.fin  = 1'b1;
		if (int'(qx) >= cols || int'(qy) >= rows || blocked[int'(qy) * COLS + int'(qx)]) begin
			h.st = STATUS_BAD;
			due_hops.push_back(h);
		end else begin
			for (int k = 0; k < 8; k++) begin
				nx = int'(qx) + nbr_dx[k];
				ny = int'(qy) + nbr_dy[k];
				if (nx >= 0 && ny >= 0 && nx < cols && ny < rows) begin
					if (!blocked[ny * COLS + nx]) begin
						hops[found].nx   = nx[COORD_W-1:0];
						hops[found].ny   = ny[COORD_W-1:0];
						hops[found].diag = (nbr_dx[k] != 0 && nbr_dy[k] != 0);
						hops[found].st   = STATUS_OK;
						hops[found].fin  = 1'b0;
						found++;
					end
				end
			end
			if (found == 0) begin
				h.st = STATUS_NONE;
				due_hops.push_back(h);
			end else begin
				hops[found-1].fin = 1'b1;
				for (int k = 0; k < found; k++)
					due_hops.push_back(hops[k]);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		hop_t exp_h;
		if (!arst_n) begin
			foreach (blocked[i])
				blocked[i] = 1'b0;
			width_reg  = EXT_RESET;
			height_reg = EXT_RESET;
			due_hops.delete();
			errs       = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// results first, so a stray one never matches an item accepted this edge
			if (result_strobe) begin
				if (due_hops.size() == 0) begin
					if (errs < 10)
						$display("unexpected result: x=%0d y=%0d diag=%0b status=%0d last=%0b",
							neighbor_x, neighbor_y, is_diagonal, status, last);
					errs++;
				end else begin
					exp_h = due_hops.pop_front();
					if (neighbor_x !== exp_h.nx || neighbor_y !== exp_h.ny ||
							is_diagonal !== exp_h.diag || status !== exp_h.st ||
							last !== exp_h.fin) begin
						// fields: x, y, diag, status, last
						if (errs < 10)
							$display("mismatch: exp %0d,%0d,%0b,%0d,%0b got %0d,%0d,%0b,%0d,%0b",
								exp_h.nx, exp_h.ny, exp_h.diag, exp_h.st, exp_h.fin,
								neighbor_x, neighbor_y, is_diagonal, status, last);
						errs++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_GRID_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == CFG_GRID_HEIGHT)
					height_reg = cfg_data;
			end
			if (start && !busy) begin
				if (op_t'(opcode) == OP_WRITE) begin
					if (int'(cell_x) < span(width_reg, COLS) && int'(cell_y) < span(height_reg, ROWS))
						blocked[int'(cell_y) * COLS + int'(cell_x)] = occupied_in;
				end else begin
					expand_query(cell_x, cell_y);
				end
			end
			fail_count <= errs;
			pending    <= due_hops.size();
		end
	end

endmodule

/* tb/grid_neighbor_expander_tb.sv */
module grid_neighbor_expander_tb;
	import gne_pkg::*;

	// Run limit: covers ~500 commands, each with its worst busy time and longest gap,
	// plus the clearing pass and phase pauses.
	localparam int RUN_LIMIT   = 200000 * 20;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 45;
	localparam int SETTLE      = 16;   // covers write tail and query flush

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               opcode;
	logic [COORD_W-1:0] cell_x;
	logic [COORD_W-1:0] cell_y;
	logic               occupied_in;
	logic               result_strobe;
	logic [COORD_W-1:0] neighbor_x;
	logic [COORD_W-1:0] neighbor_y;
	logic               is_diagonal;
	logic [1:0]         status;
	logic               last;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [EXT_W-1:0]   cfg_data;
	int                 fail_count;
	int                 pending;

	// grid sizes per phase; both extremes, zero (empty grid) and
	// over-range register values, last phase is drawn at random
	int phase_w [0:PHASES-1] = '{5, 1, 0, 127, 2, 64, 3, 100, 64, 0};
	int phase_h [0:PHASES-1] = '{4, 1, 0, 2, 127, 64, 3, 7, 1, 0};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	grid_neighbor_expander DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.cell_x        (cell_x),
		.cell_y        (cell_y),
		.occupied_in   (occupied_in),
		.result_strobe (result_strobe),
		.neighbor_x    (neighbor_x),
		.neighbor_y    (neighbor_y),
		.is_diagonal   (is_diagonal),
		.status        (status),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	grid_neighbor_expander_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.cell_x        (cell_x),
		.cell_y        (cell_y),
		.occupied_in   (occupied_in),
		.result_strobe (result_strobe),
		.neighbor_x    (neighbor_x),
		.neighbor_y    (neighbor_y),
		.is_diagonal   (is_diagonal),
		.status        (status),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Sender gap: mostly back to back or short, now and then a long one.
	// A quiet phase sends with no gaps at all.
	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Coordinate pick: mostly inside a small hot window so writes and queries
	// land on the same cells, some hugging the grid edge, the rest anywhere.
	function automatic logic [COORD_W-1:0] pick_coord(input int used, input int base);
		int r;
		int c;
		r = $urandom_range(0, 99);
		if (r < 70)
			c = base + $urandom_range(0, 5);
		else if (r < 85)
			c = used - 1 + $urandom_range(0, 2);
		else
			c = $urandom_range(0, 63);
		if (c < 0)
			c = 0;
		if (c > 63)
			c = 63;
		return c[COORD_W-1:0];
	endfunction

	// One command transfer. start is only lowered when a gap is wanted, so it
	// never gets two assignments in one step between back-to-back commands.
	task automatic issue(input op_t op, input int x, input int y, input bit occ, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		opcode      <= op;
		cell_x      <= x[COORD_W-1:0];
		cell_y      <= y[COORD_W-1:0];
		occupied_in <= occ;
		do @(posedge clk); while (busy);
	endtask

	// Hold off the sender until every outstanding result has come back.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Register transfer; valid stays up across consecutive writes.
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[EXT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	initial begin
		int  gw;
		int  gh;
		int  ux;
		int  uy;
		int  bx;
		int  by;
		bit  quiet;
		op_t op;

		arst_n      <= 1'b0;
		start       <= 1'b0;
		opcode      <= OP_WRITE;
		cell_x      <= '0;
		cell_y      <= '0;
		occupied_in <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= CFG_GRID_WIDTH;
		cfg_data    <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the 64x64 reset grid.
		issue(OP_QUERY, 0, 0, 0, pick_gap(0));     // corner, three neighbors
		issue(OP_QUERY, 63, 63, 0, pick_gap(0));   // far corner
		issue(OP_QUERY, 30, 30, 0, pick_gap(0));   // interior, all eight
		issue(OP_WRITE, 31, 31, 1, pick_gap(0));
		issue(OP_WRITE, 29, 30, 1, pick_gap(0));
		issue(OP_WRITE, 30, 29, 1, pick_gap(0));
		issue(OP_QUERY, 30, 30, 0, pick_gap(0));   // some neighbors blocked
		issue(OP_WRITE, 30, 30, 1, pick_gap(0));
		issue(OP_QUERY, 30, 30, 0, pick_gap(0));   // query cell itself blocked
		issue(OP_WRITE, 30, 30, 0, pick_gap(0));
		issue(OP_QUERY, 30, 30, 1, pick_gap(0));   // occupied_in ignored on a query
		issue(OP_WRITE, 1, 0, 1, pick_gap(0));
		issue(OP_WRITE, 0, 1, 1, pick_gap(0));
		issue(OP_WRITE, 1, 1, 1, pick_gap(0));
		issue(OP_QUERY, 0, 0, 0, pick_gap(0));     // fenced in: no free neighbor
		issue(OP_QUERY, 63, 0, 0, pick_gap(0));
		issue(OP_QUERY, 0, 63, 0, pick_gap(0));
		issue(OP_WRITE, 1, 1, 0, pick_gap(0));
		issue(OP_QUERY, 0, 0, 0, pick_gap(0));     // only the diagonal is free
		issue(OP_QUERY, 42, 21, 0, pick_gap(0));
		issue(OP_WRITE, 21, 42, 1, pick_gap(0));
		issue(OP_QUERY, 21, 41, 0, pick_gap(0));

		// Random phases, each under its own grid size. The map carries over,
		// so shrinking hides blocked cells and growing brings them back.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			repeat (SETTLE) @(posedge clk);
			gw = (p == PHASES - 1) ? $urandom_range(0, 127) : phase_w[p];
			gh = (p == PHASES - 1) ? $urandom_range(0, 127) : phase_h[p];
			reg_write(CFG_GRID_WIDTH, gw);
			reg_write(CFG_GRID_HEIGHT, gh);
			cfg_valid <= 1'b0;
			ux = (gw > 64) ? 64 : gw;
			uy = (gh > 64) ? 64 : gh;
			bx = (ux > 6) ? $urandom_range(0, ux - 6) : 0;
			by = (uy > 6) ? $urandom_range(0, uy - 6) : 0;
			quiet = (p % 3 == 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// occasional hold-off mid-phase until the block has caught up
				if ($urandom_range(0, 99) < 3)
					drain();
				op = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_QUERY;
				issue(op, pick_coord(ux, bx), pick_coord(uy, by),
					($urandom_range(0, 99) < 60), pick_gap(quiet));
			end
		end

		// Wait out the last results, then watch a while for strays.
		drain();
		repeat (3 * SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

endmodule
